// File: rtl/core/dct_pkg.sv
package dct_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int PEN_ADDR_W = $clog2(PALETTE_SIZE);
	localparam int PEN_W = 4;
	localparam int PHASES = 4;
	localparam int PLANES = 4;

	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic [3:0] FIRST_POS = 4'd0;
	localparam logic [3:0] LAST_POS = 4'd15;
	localparam logic [8:0] SUM_MAX = 9'd256;
	localparam logic [2:0] LAST_COLUMN = 3'd7;
	localparam logic [2:0] LAST_ROW = 3'd7;

	// 2x2 bayer ranks by phase
	localparam logic [PHASES-1:0][3:0] BAYER_RANK = {4'd4, 4'd12, 4'd8, 4'd0};

	typedef logic [PHASES*PEN_W-1:0] pens_t;

	typedef struct packed {
		logic valid;
		logic in_range;
	} pix_ctl_t;

endpackage

// File: rtl/core/dct_pen_table.sv
module dct_pen_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_go,
	input  logic          rd_go,
	input  logic [7:0]    color,
	input  logic [3:0]    pos,
	input  logic [4:0]    weight,
	output dct_pkg::pens_t pens_s2
);
	import dct_pkg::*;

	logic [8:0] sum_q, sum_base, sum_raw, sum_next;
	logic [PHASES-1:0] found_q, found_base, found_next;
	pens_t pend_q, pend_base, pend_next;
	logic in_range;
	logic [PEN_ADDR_W-1:0] addr;
	pens_t mem [PALETTE_SIZE];

	assign in_range = 9'(color) < 9'(PALETTE_SIZE);
	assign addr = color[PEN_ADDR_W-1:0];

	always_comb begin
		if (pos == FIRST_POS) begin
			sum_base = '0;
			found_base = '0;
			pend_base = '1;
		end else begin
			sum_base = sum_q;
			found_base = found_q;
			pend_base = pend_q;
		end
		sum_raw = sum_base + 9'(weight);
		sum_next = (sum_raw > SUM_MAX) ? SUM_MAX : sum_raw;
		found_next = found_base;
		pend_next = pend_base;
		for (int p = 0; p < PHASES; p++) begin
			if (!found_base[p] && (9'(BAYER_RANK[p]) < sum_next)) begin
				found_next[p] = 1'b1;
				pend_next[p*PEN_W +: PEN_W] = pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			found_q <= '0;
			pend_q <= '1;
		end else if (wr_go) begin
			sum_q <= sum_next;
			found_q <= found_next;
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go && (pos == LAST_POS) && in_range) begin
			mem[addr] <= pend_next;
		end
		if (rd_go) begin
			pens_s2 <= mem[addr];
		end
	end

endmodule

// File: rtl/core/dct_packer.sv
module dct_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  dct_pkg::pix_ctl_t pix_s2,
	input  dct_pkg::pens_t    pens_s2,
	input  logic              result_ready,
	output logic              s2_done,
	output logic              result_valid,
	output logic [7:0]        plane0_byte,
	output logic [7:0]        plane1_byte,
	output logic [7:0]        plane2_byte,
	output logic [7:0]        plane3_byte,
	output logic [2:0]        tile_row,
	output logic              tile_done
);
	import dct_pkg::*;

	logic [2:0] col_q, row_q;
	logic [PLANES-1:0][7:0] shift_q, shift_next, planes_q;
	logic [PEN_W-1:0] pen;
	logic emit;
	logic out_v_q;
	logic [2:0] row_out_q;
	logic done_out_q;

	assign emit = (col_q == LAST_COLUMN);
	assign s2_done = pix_s2.valid && (!emit || !out_v_q || result_ready);
	assign pen = pix_s2.in_range ? pens_s2[{row_q[0], col_q[0], 2'b00} +: PEN_W] : '0;

	always_comb begin
		for (int p = 0; p < PLANES; p++) begin
			shift_next[p] = {shift_q[p][6:0], pen[p]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			shift_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_done) begin
				if (emit) begin
					shift_q <= '0;
					col_q <= '0;
					row_q <= row_q + 3'd1;
				end else begin
					shift_q <= shift_next;
					col_q <= col_q + 3'd1;
				end
			end
			out_v_q <= (s2_done && emit) || (out_v_q && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done && emit) begin
			planes_q <= shift_next;
			row_out_q <= row_q;
			done_out_q <= (row_q == LAST_ROW);
		end
	end

	assign result_valid = out_v_q;
	assign plane0_byte = planes_q[0];
	assign plane1_byte = planes_q[1];
	assign plane2_byte = planes_q[2];
	assign plane3_byte = planes_q[3];
	assign tile_row = row_out_q;
	assign tile_done = done_out_q;

endmodule

// File: rtl/core/dither_chunky_to_planar_tile.sv
// ordered dither (2x2 bayer) palette pixels to four bitplanes, 8x8 tiles
// input channel: item_valid / item_ready with kind, color_index,
//   weight_position, weight_value. kind 0 loads one weight of a color's
//   16-entry row in position order; position 15 stores four pens for it.
//   kind 1 is one pixel, sent 8x8 in tile row-major order.
// output channel: result_valid / result_ready with plane0..3 bytes,
//   tile_row and tile_done, one transfer after every eighth pixel.
// throughput: one item per cycle unless a stalled result holds pixels. a
//   scanline's result is registered once its eighth pixel leaves the pen table read.
// stages: input register, pen table read (one read or one write port per
//   cycle, registered read data), pack and output register.
// a stalled receiver holds the result; pixels keep flowing until the next
//   scanline end needs the output register, then item_ready drops.
// reset clears the weight accumulator, pixel counters and pipeline valids;
//   the pen table is not cleared, a color must be loaded before its pixels.
module dither_chunky_to_planar_tile (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       kind,
	input  logic [7:0] color_index,
	input  logic [3:0] weight_position,
	input  logic [4:0] weight_value,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] plane0_byte,
	output logic [7:0] plane1_byte,
	output logic [7:0] plane2_byte,
	output logic [7:0] plane3_byte,
	output logic [2:0] tile_row,
	output logic       tile_done
);
	import dct_pkg::*;

	logic s1_v_q;
	logic kind_s1;
	logic [7:0] color_s1;
	logic [3:0] pos_s1;
	logic [4:0] weight_s1;
	logic s1_go, wr_go, rd_go, accept;
	logic s2_v_q, in_range_s2, s2_done;
	pix_ctl_t pix_s2;
	pens_t pens_s2;

	assign accept = item_valid && item_ready;
	assign s1_go = s1_v_q && ((kind_s1 == KIND_WEIGHT) || !s2_v_q || s2_done);
	assign wr_go = s1_go && (kind_s1 == KIND_WEIGHT);
	assign rd_go = s1_go && (kind_s1 == KIND_PIXEL);
	assign item_ready = !s1_v_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept || (s1_v_q && !s1_go);
			s2_v_q <= rd_go || (s2_v_q && !s2_done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			color_s1 <= color_index;
			pos_s1 <= weight_position;
			weight_s1 <= weight_value;
		end
		if (rd_go) begin
			in_range_s2 <= 9'(color_s1) < 9'(PALETTE_SIZE);
		end
	end

	assign pix_s2.valid = s2_v_q;
	assign pix_s2.in_range = in_range_s2;

	dct_pen_table u_pen_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_go   (wr_go),
		.rd_go   (rd_go),
		.color   (color_s1),
		.pos     (pos_s1),
		.weight  (weight_s1),
		.pens_s2 (pens_s2)
	);

	dct_packer u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_s2       (pix_s2),
		.pens_s2      (pens_s2),
		.result_ready (result_ready),
		.s2_done      (s2_done),
		.result_valid (result_valid),
		.plane0_byte  (plane0_byte),
		.plane1_byte  (plane1_byte),
		.plane2_byte  (plane2_byte),
		.plane3_byte  (plane3_byte),
		.tile_row     (tile_row),
		.tile_done    (tile_done)
	);

endmodule

// File: rtl/core/dct_checker.sv
module dct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] plane0_byte,
	input logic [7:0] plane1_byte,
	input logic [7:0] plane2_byte,
	input logic [7:0] plane3_byte,
	input logic [2:0] tile_row,
	input logic       tile_done
);

	// a waiting result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(plane0_byte) &&
		$stable(plane1_byte) && $stable(plane2_byte) && $stable(plane3_byte) &&
		$stable(tile_row))
		else $error("result changed while stalled");

	// last scanline flag follows the row
	a_tile_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (tile_done == (tile_row == 3'd7)))
		else $error("tile_done does not match tile_row");

	// empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");

	// nothing is shown right after reset release
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

endmodule

bind dither_chunky_to_planar_tile dct_checker u_dct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.plane0_byte  (plane0_byte),
	.plane1_byte  (plane1_byte),
	.plane2_byte  (plane2_byte),
	.plane3_byte  (plane3_byte),
	.tile_row     (tile_row),
	.tile_done    (tile_done)
);
